FILE: sv/bhbi_pkg.sv
// Shared types, constants and residue tables for the byte hash bucket index unit.
package bhbi_pkg;

   localparam int unsigned HASH_W      = 64;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned LEN_W       = 16;
   localparam int unsigned BKT_CNT_W   = 21;
   localparam int unsigned BKT_IDX_W   = 20;
   localparam int unsigned REQ_DATA_W  = 24;
   localparam int unsigned RSP_DATA_W  = 88;
   localparam int unsigned DIV_CNT_W   = 6;

   localparam logic [4:0]           SHL_PERIOD  = 5'd24;
   localparam logic [6:0]           MIX_PERIOD  = 7'd42;
   localparam logic [5:0]           MIX_BASE    = 6'd63;
   localparam logic [BKT_CNT_W-1:0] MAX_BUCKETS = 21'd1048576;
   localparam logic [BKT_CNT_W-1:0] BKT_RESET   = 21'd1024;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST    = 6'd63;

   typedef logic [5:0] mod_table_type [256];

   // residue of the low length byte modulo 42
   function automatic mod_table_type build_lo_mod();
      mod_table_type t;
      logic [6:0]    c;
      c = '0;
      for (int i = 0; i < 256; i++) begin
         t[i] = c[5:0];
         c = (c == MIX_PERIOD - 7'd1) ? 7'd0 : c + 7'd1;
      end
      return t;
   endfunction

   // residue of (high length byte * 256) modulo 42; 256 mod 42 is 4
   function automatic mod_table_type build_hi_mod();
      mod_table_type t;
      logic [6:0]    c;
      c = '0;
      for (int i = 0; i < 256; i++) begin
         t[i] = c[5:0];
         c = c + 7'd4;
         if (c >= MIX_PERIOD) begin
            c = c - MIX_PERIOD;
         end
      end
      return t;
   endfunction

   localparam mod_table_type LEN_LO_MOD = build_lo_mod();
   localparam mod_table_type LEN_HI_MOD = build_hi_mod();

   typedef struct packed {
      logic a_load;
      logic a_apply;
      logic div_start;
      logic div_step;
      logic out_load;
   } bhbi_cmd_type;

   typedef struct packed {
      logic a_last;
   } bhbi_stat_type;

endpackage

FILE: sv/byte_hash_bucket_index_unit.sv
// Byte hash bucket index unit: streams key bytes into a 64-bit hash and bucket index.
// Throughput: one key byte per cycle; a key's final beat waits while the previous
//   key's bit-serial modulo runs or its result waits to enter the result register.
// Result path: final beat's input register, bit-serial modulo run, hold state, result register.
// Reset (synchronous, active high) clears hash, position, handshakes and sets
//   bucket_count to 1024.
module byte_hash_bucket_index_unit
   import bhbi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] key_byte, [23:8] key_length
   input  logic                  req_tlast,   // last_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [63:0] hash_value, [83:64] bucket_index
   input  logic                  csr_wr_en,
   input  logic [BKT_CNT_W-1:0]  csr_wr_data  // bucket_count
);

   bhbi_cmd_type  cmd;
   bhbi_stat_type stat;

   bhbi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bhbi_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

FILE: sv/bhbi_ctrl.sv
// Controller: input stage occupancy, divider sequencing and result register handshake.
module bhbi_ctrl
   import bhbi_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  bhbi_stat_type stat,
   output bhbi_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 a_valid_ff, a_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 apply;
   logic                 fire;

   assign apply      = a_valid_ff & (~stat.a_last | (state_ff == ST_IDLE));
   assign req_tready = ~a_valid_ff | apply;
   assign fire       = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd.a_load    = fire;
      cmd.a_apply   = apply;
      cmd.div_start = apply & stat.a_last;
      cmd.div_step  = 1'b0;
      cmd.out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.div_start) begin
               state_in = ST_RUN;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (~rsp_valid_ff | rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign a_valid_in   = fire ? 1'b1 : (apply ? 1'b0 : a_valid_ff);
   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> state_ff == ST_RUN)
      else $error("divider start did not enter run");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && cnt_ff == DIV_LAST) |=> state_ff == ST_HOLD)
      else $error("divider did not finish after 64 steps");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result load did not raise valid");

   a_last_waits: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && stat.a_last && state_ff != ST_IDLE) |-> !req_tready)
      else $error("final beat applied while divider busy");

endmodule

FILE: sv/bhbi_dpath.sv
// Datapath: shift residues, hash update, restoring modulo divider and result register.
module bhbi_dpath
   import bhbi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   input  logic                  csr_wr_en,
   input  logic [BKT_CNT_W-1:0]  csr_wr_data,
   input  bhbi_cmd_type          cmd,
   output bhbi_stat_type         stat,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [BYTE_W-1:0]    key_byte;
   logic [LEN_W-1:0]     key_length;

   logic [LEN_W-1:0]     pos_ff, pos_in;
   logic [4:0]           pos24_ff, pos24_in;
   logic [5:0]           pos42_ff, pos42_in;

   logic [BYTE_W-1:0]    kb_a_ff;
   logic                 last_a_ff;
   logic [4:0]           shl_a_ff;
   logic [5:0]           mix_a_ff;

   logic [6:0]           len_sum;
   logic [5:0]           len_mod;
   logic [6:0]           mix_sum;
   logic [5:0]           mix_mod;

   logic [HASH_W-1:0]    hash_ff;
   logic [HASH_W-1:0]    h1, h2;

   logic [BKT_CNT_W-1:0] bkt_cnt_ff;
   logic [BKT_CNT_W-1:0] nb_eff;
   logic [BKT_CNT_W-1:0] nb_ff;
   logic [HASH_W-1:0]    dvd_ff;
   logic [HASH_W-1:0]    hold_ff;
   logic [BKT_IDX_W-1:0] rem_ff;
   logic [BKT_CNT_W-1:0] trial;
   logic [BKT_CNT_W-1:0] diff;

   logic [HASH_W-1:0]    out_hash_ff;
   logic [BKT_IDX_W-1:0] out_bkt_ff;

   assign key_byte   = req_tdata[7:0];
   assign key_length = req_tdata[23:8];

   // position residues tracked as counters; a 16-bit wrap restarts them
   always_comb begin
      pos_in   = pos_ff + 1'b1;
      pos24_in = (pos24_ff == SHL_PERIOD - 5'd1) ? 5'd0 : pos24_ff + 1'b1;
      pos42_in = (pos42_ff == 6'(MIX_PERIOD - 7'd1)) ? 6'd0 : pos42_ff + 1'b1;
      if (req_tlast || pos_ff == '1) begin
         pos24_in = '0;
         pos42_in = '0;
      end
      if (req_tlast) begin
         pos_in = '0;
      end
   end

   always_comb begin
      len_sum = {1'b0, LEN_LO_MOD[key_length[7:0]]} + {1'b0, LEN_HI_MOD[key_length[15:8]]};
      len_mod = (len_sum >= MIX_PERIOD) ? 6'(len_sum - MIX_PERIOD) : len_sum[5:0];
      mix_sum = {1'b0, len_mod} + {1'b0, pos42_ff};
      mix_mod = (mix_sum >= MIX_PERIOD) ? 6'(mix_sum - MIX_PERIOD) : mix_sum[5:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         pos24_ff <= '0;
         pos42_ff <= '0;
      end else if (cmd.a_load) begin
         pos_ff   <= pos_in;
         pos24_ff <= pos24_in;
         pos42_ff <= pos42_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.a_load) begin
         kb_a_ff   <= key_byte;
         last_a_ff <= req_tlast;
         shl_a_ff  <= pos24_ff + 5'd1;
         mix_a_ff  <= mix_mod + 6'd1;
      end
   end

   assign stat.a_last = last_a_ff;

   always_comb begin
      h1 = hash_ff + {{(HASH_W-BYTE_W){1'b0}}, kb_a_ff} + (hash_ff << shl_a_ff);
      h2 = h1 ^ ((h1 << mix_a_ff) | (h1 >> (MIX_BASE - mix_a_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
      end else if (cmd.a_apply) begin
         hash_ff <= last_a_ff ? '0 : h2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bkt_cnt_ff <= BKT_RESET;
      end else if (csr_wr_en) begin
         bkt_cnt_ff <= csr_wr_data;
      end
   end

   always_comb begin
      nb_eff = bkt_cnt_ff;
      if (bkt_cnt_ff == '0) begin
         nb_eff = BKT_CNT_W'(1);
      end else if (bkt_cnt_ff > MAX_BUCKETS) begin
         nb_eff = MAX_BUCKETS;
      end
   end

   // one quotient bit per cycle, MSB first
   assign trial = {rem_ff, dvd_ff[HASH_W-1]};
   assign diff  = trial - nb_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dvd_ff  <= h2;
         hold_ff <= h2;
         rem_ff  <= '0;
         nb_ff   <= nb_eff;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[HASH_W-2:0], 1'b0};
         rem_ff <= (trial >= nb_ff) ? diff[BKT_IDX_W-1:0] : trial[BKT_IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_hash_ff <= hold_ff;
         out_bkt_ff  <= rem_ff;
      end
   end

   assign rsp_tdata = {{(RSP_DATA_W-HASH_W-BKT_IDX_W){1'b0}}, out_bkt_ff, out_hash_ff};

endmodule

FILE: dv/tb.sv
// Testbench for byte_hash_bucket_index_unit: streamed key bytes checked against a hash predictor.
`timescale 1ns / 100ps

module tb;
   import bhbi_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 3_000_000;
   localparam int unsigned SETTLE_CYC   = 80;
   localparam int unsigned PHASE_BEATS  = 200;

   typedef struct {
      logic [BYTE_W-1:0] kb;
      logic [LEN_W-1:0]  klen;
      logic              last;
   } key_beat_type;

   typedef struct {
      logic [HASH_W-1:0]    hash;
      logic [BKT_IDX_W-1:0] bucket;
   } digest_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;    // [7:0] key_byte, [23:8] key_length
   logic                  req_tlast;    // last_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;    // [63:0] hash_value, [83:64] bucket_index
   logic                  csr_wr_en;
   logic [BKT_CNT_W-1:0]  csr_wr_data;

   key_beat_type beat_q[$];
   digest_type   digest_q[$];

   // predictor state
   logic [HASH_W-1:0]    run_hash;
   logic [LEN_W-1:0]     run_pos;
   logic [BKT_CNT_W-1:0] bucket_cfg;

   key_beat_type cur_beat;
   digest_type   want;
   bit           beat_taken;
   int unsigned  burst_left;
   int unsigned  gap_left;
   int unsigned  rsp_mode;
   int unsigned  rsp_mode_left;
   int unsigned  cyc;
   int unsigned  err_cnt;
   int unsigned  beats_sent;
   int unsigned  keys_done;
   int unsigned  cfg_writes;
   int unsigned  phase_beats;

   byte_hash_bucket_index_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0d: %s", cyc, msg);
      err_cnt++;
   endtask

   task automatic absorb_key_byte(input logic [BYTE_W-1:0] kb, input logic [LEN_W-1:0] klen,
                                  input logic last);
      logic [HASH_W-1:0]    h;
      int unsigned          sh;
      logic [BKT_CNT_W-1:0] nb;
      digest_type           d;
      h  = run_hash + {56'd0, kb} + (run_hash << (run_pos % 24 + 1));
      sh = (32'(klen) + 32'(run_pos)) % 42 + 1;
      h  = h ^ ((h << sh) | (h >> (63 - sh)));
      if (!last) begin
         run_hash = h;
         run_pos  = run_pos + 16'd1;
      end else begin
         nb = bucket_cfg;
         if (nb == '0)
            nb = 21'd1;
         if (nb > MAX_BUCKETS)
            nb = MAX_BUCKETS;
         d.hash   = h;
         d.bucket = BKT_IDX_W'(h % {43'd0, nb});
         digest_q.push_back(d);
         run_hash = '0;
         run_pos  = '0;
      end
   endtask

   // prediction on accepted beats, checking on accepted results
   always @(posedge clock) begin
      if (reset) begin
         run_hash   = '0;
         run_pos    = '0;
         bucket_cfg = BKT_RESET;
      end else begin
         if (csr_wr_en)
            bucket_cfg = csr_wr_data;
         if (req_tvalid && req_tready) begin
            absorb_key_byte(req_tdata[7:0], req_tdata[23:8], req_tlast);
            beat_taken = 1'b1;
            beats_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (digest_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", rsp_tdata));
            end else begin
               want = digest_q.pop_front();
               keys_done++;
               if (rsp_tdata[63:0] !== want.hash)
                  report_mismatch($sformatf("hash_value %h, want %h",
                                            rsp_tdata[63:0], want.hash));
               if (rsp_tdata[83:64] !== want.bucket)
                  report_mismatch($sformatf("bucket_index %h, want %h",
                                            rsp_tdata[83:64], want.bucket));
               if (rsp_tdata[87:84] !== 4'd0)
                  report_mismatch($sformatf("pad bits %h", rsp_tdata[87:84]));
            end
         end
      end
   end

   // key byte driver: bursts with gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !beat_taken)) begin
         beat_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (beat_q.size() > 0) begin
            cur_beat = beat_q.pop_front();
            req_tdata  <= {cur_beat.klen, cur_beat.kb};
            req_tlast  <= cur_beat.last;
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               if ($urandom_range(0, 7) == 0) begin
                  burst_left = 64;
                  gap_left   = 0;
               end else begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = $urandom_range(0, 5);
               end
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (rsp_mode_left == 0) begin
         rsp_mode      = $urandom_range(0, 3);
         rsp_mode_left = $urandom_range(50, 400);
      end else begin
         rsp_mode_left--;
      end
      case (rsp_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (cyc[3:1] != 3'd5);
      endcase
   end

   always @(posedge clock) begin
      cyc++;
      if (cyc == CYCLE_LIMIT) begin
         $display("timeout: %0d results still expected", digest_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic push_beat(input logic [BYTE_W-1:0] kb, input logic [LEN_W-1:0] klen,
                            input logic last);
      key_beat_type b;
      b.kb   = kb;
      b.klen = klen;
      b.last = last;
      beat_q.push_back(b);
      phase_beats++;
   endtask

   task automatic push_random_key();
      int unsigned          n;
      int unsigned          pick;
      logic [LEN_W-1:0]     klen;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 100) : $urandom_range(1, 24);
      pick = $urandom_range(0, 99);
      if (pick < 70)
         klen = LEN_W'(n);
      else if (pick < 85)
         klen = LEN_W'($urandom_range(0, 65535));
      else
         klen = LEN_W'(n + $urandom_range(0, 6) - 3);
      for (int i = 0; i < n; i++) begin
         if (pick >= 95)
            klen = LEN_W'($urandom_range(0, 65535));
         push_beat(BYTE_W'($urandom_range(0, 255)), klen, i == n - 1);
      end
   endtask

   // holds off until the block has drained and settled
   task automatic wait_idle();
      while (beat_q.size() != 0 || req_tvalid || digest_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYC) @(negedge clock);
   endtask

   task automatic write_bucket_count(input logic [BKT_CNT_W-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cfg_writes++;
   endtask

   logic [BKT_CNT_W-1:0] cfg_list[9];

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tlast     = 1'b0;
      rsp_tready    = 1'b0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      beat_taken    = 1'b0;
      burst_left    = 1;
      gap_left      = 0;
      rsp_mode      = 0;
      rsp_mode_left = 0;
      cyc           = 0;
      err_cnt       = 0;
      beats_sent    = 0;
      keys_done     = 0;
      cfg_writes    = 0;
      phase_beats   = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed keys at the reset bucket count
      push_beat(8'h00, 16'd1, 1'b1);
      push_beat(8'hFF, 16'hFFFF, 1'b1);
      push_beat(8'h80, 16'd0, 1'b1);
      push_beat(8'h00, 16'd3, 1'b0);
      push_beat(8'hFF, 16'd3, 1'b0);
      push_beat(8'h55, 16'd3, 1'b1);
      // more bytes than the length says
      for (int i = 0; i < 4; i++)
         push_beat(8'hAA, 16'd2, i == 3);
      // fewer bytes than the length says
      push_beat(8'h01, 16'd9, 1'b0);
      push_beat(8'hFE, 16'd9, 1'b1);
      // length changing from byte to byte
      push_beat(8'h7F, 16'd1, 1'b0);
      push_beat(8'h80, 16'hFFFF, 1'b0);
      push_beat(8'h33, 16'h8000, 1'b1);
      for (int i = 0; i < 6; i++)
         push_beat(BYTE_W'(8'h5A ^ i), 16'hAAAA, i == 5);

      cfg_list = '{21'd0, 21'd1, MAX_BUCKETS, 21'h1FFFFF, 21'd1048575, 21'd3,
                   BKT_CNT_W'($urandom_range(1, 2097151)),
                   BKT_CNT_W'($urandom_range(2, 4096)), BKT_RESET};
      foreach (cfg_list[k]) begin
         write_bucket_count(cfg_list[k]);
         phase_beats = 0;
         while (phase_beats < PHASE_BEATS)
            push_random_key();
      end

      wait_idle();
      if (digest_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", digest_q.size()));
      $display("covered %0d key beats, %0d keys hashed, %0d bucket count settings",
               beats_sent, keys_done, cfg_writes);
      $display("including zero, one, max and over-max buckets and odd key lengths");
      if (err_cnt == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", err_cnt);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/bhbi_pkg.sv
sv/bhbi_ctrl.sv
sv/bhbi_dpath.sv
sv/byte_hash_bucket_index_unit.sv
dv/tb.sv
